FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define BCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bca check failed");

// Check a property on every rising edge, reset included.
`define BCA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bca reset check failed");

`endif

FILE: rtl/bca_pkg.sv
// Types and constants of the bitmap contiguous block allocator.
package bca_pkg;

  localparam int CMD_W   = 3;
  localparam int COUNT_W = 6;
  localparam int START_W = 5;
  localparam int BASE_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_ALL   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TEST      = 3'd4;

  typedef struct packed {
    logic clr;
    logic step;
    logic free;
  } trk_ctl_t;

endpackage

FILE: rtl/bca_if.sv
// Valid/ready channel interfaces for commands and results.
interface bca_in_if;
  logic                              valid;
  logic                              ready;
  logic [bca_pkg::CMD_W-1:0]         command;
  logic [bca_pkg::COUNT_W-1:0]       count;
  logic [bca_pkg::START_W-1:0]       start_req;

  modport source (output valid, command, count, start_req, input ready);
  modport sink   (input valid, command, count, start_req, output ready);
endinterface

interface bca_out_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic [bca_pkg::BASE_W-1:0]        base;
  logic                              bit_value;

  modport source (output valid, status, base, bit_value, input ready);
  modport sink   (input valid, status, base, bit_value, output ready);
endinterface

FILE: rtl/bca_map_ram.sv
// Usage bitmap memory with one write port and one registered read port.
module bca_map_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bca_run_track.sv
// Free-run counter that tracks the current run of free blocks during a scan.
module bca_run_track #(
  parameter int IW   = 7,
  parameter int CNTW = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bca_pkg::trk_ctl_t ctl,
  input  logic [IW-1:0]     addr,
  input  logic [CNTW-1:0]   need,
  output logic              found,
  output logic [IW-1:0]     first_sel
);

  logic [CNTW-1:0] run_r;
  logic [CNTW-1:0] run_nxt;
  logic [CNTW-1:0] run_inc;
  logic [IW-1:0]   first_r;
  logic [IW-1:0]   first_nxt;

  assign run_inc   = run_r + CNTW'(1);
  assign first_sel = (run_r == '0) ? addr : first_r;
  assign found     = ctl.step && ctl.free && (run_inc == need);

  always_comb begin
    run_nxt   = run_r;
    first_nxt = first_r;
    if (ctl.clr) begin
      run_nxt = '0;
    end else if (ctl.step) begin
      if (ctl.free) begin
        run_nxt   = run_inc;
        first_nxt = first_sel;
      end else begin
        run_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
    first_r <= first_nxt;
  end

endmodule

FILE: rtl/bitmap_contiguous_block_allocator.sv
// Top level of the bitmap first-fit contiguous block allocator.
//
//   channel  dir  payload                           transfer
//   in_ch    in   command, count, start_req         valid && ready
//   out_ch   out  status, base, bit_value           valid && ready
//
// One command at a time; in_ch.ready is high only while the sequencer is idle.
// Allocate: scan one block per cycle through the memory read port, then mark
//   count blocks, then post. Release: free up to count blocks from start_req,
//   up to the end of the map. Clear/set all: write every block. Test: read one
//   bit. After reset a clearing pass over all BLOCKS blocks runs first.
// A result waiting in the output register stalls only the final post step.
module bitmap_contiguous_block_allocator #(
  parameter int BLOCKS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  bca_in_if.sink        in_ch,
  bca_out_if.source     out_ch
);

  localparam int AW   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int IW   = (AW + 1 > 7) ? AW + 1 : 7;
  localparam int CNTW = ($clog2(BLOCKS + 1) > 6) ? $clog2(BLOCKS + 1) : 6;
  localparam logic [IW-1:0]   LAST  = IW'(BLOCKS - 1);
  localparam logic [IW-1:0]   LIMIT = IW'(BLOCKS);
  localparam logic [CNTW-1:0] MAXN  = CNTW'(BLOCKS);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MARK = 3'd3;
  localparam logic [2:0] S_REL  = 3'd4;
  localparam logic [2:0] S_TRD  = 3'd5;
  localparam logic [2:0] S_TWT  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [CNTW-1:0]             rem_r, rem_nxt;
  logic [CNTW-1:0]             need_r, need_nxt;
  logic                        pend_r, pend_nxt;
  logic [IW-1:0]               pend_addr_r, pend_addr_nxt;
  logic                        fill_r, fill_nxt;
  logic                        rs_status_r, rs_status_nxt;
  logic [bca_pkg::BASE_W-1:0]  rs_base_r, rs_base_nxt;
  logic                        rs_bit_r, rs_bit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_status_r, out_status_nxt;
  logic [bca_pkg::BASE_W-1:0]  out_base_r, out_base_nxt;
  logic                        out_bit_r, out_bit_nxt;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic                        ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic                        ram_rdata;

  bca_pkg::trk_ctl_t           trk_ctl;
  logic                        trk_found;
  logic [IW-1:0]               trk_first;

  logic                        in_xfer;
  logic                        out_free;
  logic [CNTW-1:0]             req_count;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign in_xfer          = in_ch.valid && (state_r == S_IDLE);
  assign out_free         = !out_valid_r || out_ch.ready;
  assign req_count        = CNTW'(in_ch.count);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.base      = out_base_r;
  assign out_ch.bit_value = out_bit_r;

  bca_map_ram #(
    .DEPTH (BLOCKS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bca_run_track #(
    .IW   (IW),
    .CNTW (CNTW)
  ) u_trk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (trk_ctl),
    .addr      (pend_addr_r),
    .need      (need_r),
    .found     (trk_found),
    .first_sel (trk_first)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    need_nxt       = need_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    fill_nxt       = fill_r;
    rs_status_nxt  = rs_status_r;
    rs_base_nxt    = rs_base_r;
    rs_bit_nxt     = rs_bit_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_bit_nxt    = out_bit_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = fill_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];
    trk_ctl        = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          rs_status_nxt = 1'b0;
          rs_base_nxt   = '0;
          rs_bit_nxt    = 1'b0;
          pend_nxt      = 1'b0;
          idx_nxt       = '0;
          unique case (in_ch.command)
            bca_pkg::CMD_ALLOC: begin
              need_nxt = req_count;
              if (req_count == '0 || req_count > MAXN) begin
                rs_status_nxt = 1'b1;
                state_nxt     = S_DONE;
              end else begin
                trk_ctl.clr = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            bca_pkg::CMD_RELEASE: begin
              idx_nxt   = IW'(in_ch.start_req);
              rem_nxt   = req_count;
              state_nxt = S_REL;
            end
            bca_pkg::CMD_CLEAR_ALL: begin
              fill_nxt  = 1'b0;
              state_nxt = S_CLR;
            end
            bca_pkg::CMD_SET_ALL: begin
              fill_nxt  = 1'b1;
              state_nxt = S_CLR;
            end
            bca_pkg::CMD_TEST: begin
              idx_nxt = IW'(in_ch.start_req);
              if (IW'(in_ch.start_req) < LIMIT) begin
                state_nxt = S_TRD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r < LIMIT) begin
          ram_re        = 1'b1;
          idx_nxt       = idx_r + IW'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          trk_ctl.step = 1'b1;
          trk_ctl.free = !ram_rdata;
          if (trk_found) begin
            rs_base_nxt = trk_first[bca_pkg::BASE_W-1:0];
            idx_nxt     = trk_first;
            rem_nxt     = need_r;
            state_nxt   = S_MARK;
          end else if (pend_addr_r == LAST) begin
            rs_status_nxt = 1'b1;
            state_nxt     = S_DONE;
          end
        end
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        idx_nxt   = idx_r + IW'(1);
        rem_nxt   = rem_r - CNTW'(1);
        if (rem_r == CNTW'(1)) begin
          state_nxt = S_DONE;
        end
      end
      S_REL: begin
        if (rem_r == '0 || idx_r >= LIMIT) begin
          state_nxt = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = 1'b0;
          idx_nxt   = idx_r + IW'(1);
          rem_nxt   = rem_r - CNTW'(1);
        end
      end
      S_TRD: begin
        ram_re    = 1'b1;
        state_nxt = S_TWT;
      end
      S_TWT: begin
        rs_bit_nxt = ram_rdata;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rs_status_r;
          out_base_nxt   = rs_base_r;
          out_bit_nxt    = rs_bit_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      fill_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The clearing pass after reset posts no result.
      if (state_r == S_CLR && state_nxt == S_DONE && !rs_status_r && rs_base_r == '1) begin
        state_r <= S_IDLE;
      end else begin
        state_r <= state_nxt;
      end
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r        <= rem_nxt;
    need_r       <= need_nxt;
    pend_addr_r  <= pend_addr_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_bit_r    <= out_bit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_status_r <= 1'b0;
      rs_base_r   <= '1;
      rs_bit_r    <= 1'b0;
    end else begin
      rs_status_r <= rs_status_nxt;
      rs_base_r   <= rs_base_nxt;
      rs_bit_r    <= rs_bit_nxt;
    end
  end

endmodule

FILE: rtl/bca_checker.sv
// Port-level checker for the allocator, bound to the top level.
`include "assert_macros.svh"

module bca_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_status,
  input logic [bca_pkg::BASE_W-1:0]  out_base,
  input logic                        out_bit_value
);

  `BCA_ASSERT_RST(a_no_result_after_reset, !rst_n |=> !out_valid)
  `BCA_ASSERT(a_fail_fields_zero, out_valid && out_status |-> out_base == '0 && !out_bit_value)
  `BCA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)
  `BCA_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid)

endmodule

bind bitmap_contiguous_block_allocator bca_checker u_bca_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_base      (out_ch.base),
  .out_bit_value (out_ch.bit_value)
);
